FILE: rtl/core/touch_event_slot_filter_scaler_defines.svh
// Assertion macros for the touch event slot filter and scaler.
`ifndef TOUCH_EVENT_SLOT_FILTER_SCALER_DEFINES_SVH
`define TOUCH_EVENT_SLOT_FILTER_SCALER_DEFINES_SVH
`ifndef ASSERT_OFF
`define TESSF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TESSF_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define TESSF_ASSERT(lbl, prop, msg)
`define TESSF_NEVER(lbl, cond, msg)
`endif
`endif

FILE: rtl/core/tessf_pkg.sv
// Package: types and constants of the touch event slot filter and scaler.
package tessf_pkg;
	localparam int NW = 54;
	localparam int DW = 18;
	localparam int MAW = 34;
	localparam int MBW = 18;
	localparam int PW = MAW + MBW;
	localparam int CW = $clog2(NW + 1);

	localparam logic [4:0] EV_SYN = 5'd0;
	localparam logic [4:0] EV_KEY = 5'd1;
	localparam logic [4:0] EV_ABS = 5'd3;

	localparam logic [9:0] KEY_FINGER = 10'd325;
	localparam logic [9:0] KEY_TAP5 = 10'd328;
	localparam logic [9:0] KEY_TOUCH = 10'd330;
	localparam logic [9:0] KEY_TAP2 = 10'd333;
	localparam logic [9:0] KEY_TAP3 = 10'd334;
	localparam logic [9:0] KEY_TAP4 = 10'd335;

	localparam logic [9:0] ABS_X = 10'd0;
	localparam logic [9:0] ABS_Y = 10'd1;
	localparam logic [9:0] ABS_PRESS = 10'd24;
	localparam logic [9:0] ABS_SLOT_SEL = 10'd47;
	localparam logic [9:0] ABS_MT_POS_X = 10'd53;
	localparam logic [9:0] ABS_MT_POS_Y = 10'd54;
	localparam logic [9:0] ABS_TRACK_ID = 10'd57;
	localparam logic [9:0] ABS_MT_PRESS = 10'd58;

	localparam logic [2:0] REG_SCALE_PERCENT = 3'd0;
	localparam logic [2:0] REG_DEST_SLOT_COUNT = 3'd1;
	localparam logic [2:0] REG_START_SLOT = 3'd2;
	localparam logic [2:0] REG_DEST_AXIS_MASK = 3'd3;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_BEGIN = 2'd1,
		ST_UPDATE = 2'd2,
		ST_END = 2'd3
	} slot_state_t;

	typedef enum logic [3:0] {
		SC_IDLE,
		SC_MUL_D,
		SC_LO_START,
		SC_LO_WAIT,
		SC_HI_START,
		SC_HI_WAIT,
		SC_CLAMP,
		SC_MUL_V,
		SC_MUL_M,
		SC_DIV_START,
		SC_DIV_WAIT,
		SC_DONE
	} sc_state_t;

	typedef struct packed {
		logic start;
		logic signed [NW-1:0] numer;
		logic signed [DW-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic signed [NW-1:0] quot;
	} div_rsp_t;
endpackage

FILE: rtl/core/tessf_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
module tessf_div (
	input logic clk,
	input logic arst_n,
	input tessf_pkg::div_req_t req,
	output tessf_pkg::div_rsp_t rsp
);
	import tessf_pkg::*;

	logic busy_q;
	logic done_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] q_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dv_q;
	logic [DW:0] trial;
	logic take;
	logic [NW-1:0] mag_n;
	logic [DW-1:0] mag_d;

	assign mag_n = req.numer[NW-1] ? NW'(-req.numer) : NW'(req.numer);
	assign mag_d = req.denom[DW-1] ? DW'(-req.denom) : DW'(req.denom);
	assign trial = {rem_q, q_q[NW-1]};
	assign take = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= mag_n;
			rem_q <= '0;
			dv_q <= mag_d;
			neg_q <= req.numer[NW-1] ^ req.denom[DW-1];
		end else if (busy_q) begin
			rem_q <= take ? DW'(trial - {1'b0, dv_q}) : DW'(trial);
			q_q <= {q_q[NW-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule

FILE: rtl/core/tessf_scale.sv
// Rescale sequencer: one shared multiplier and the serial divider.
module tessf_scale (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] ranges,
	input logic [6:0] pct,
	input logic signed [31:0] value,
	output logic done,
	output logic signed [31:0] result
);
	import tessf_pkg::*;

	sc_state_t state_q, state_d;
	logic signed [DW-1:0] smin_q, smax_q;
	logic signed [DW-1:0] dmin_q, drange_q;
	logic signed [MAW-1:0] v_q;
	logic signed [PW-1:0] prod_q, acc_q;
	logic signed [31:0] res_q;
	logic signed [DW-1:0] srange;
	logic signed [MAW-1:0] mul_a;
	logic signed [MBW-1:0] mul_b;
	logic signed [PW-1:0] product;
	logic signed [MAW-1:0] vc;
	logic signed [NW-1:0] quot;
	logic clamp_en;
	div_req_t dreq;
	div_rsp_t drsp;

	assign clamp_en = (pct >= 7'd1) && (pct <= 7'd99);
	assign srange = smax_q - smin_q;
	assign product = mul_a * mul_b;
	assign quot = drsp.quot;

	tessf_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	always_comb begin
		mul_a = MAW'(v_q - MAW'(smin_q));
		mul_b = MBW'(drange_q);
		case (state_q)
			SC_MUL_D: begin
				mul_a = MAW'($signed({1'b0, 7'd100 - pct}));
				mul_b = MBW'(srange);
			end
			SC_MUL_M: begin
				mul_a = MAW'(dmin_q);
				mul_b = MBW'(srange);
			end
			default: ;
		endcase
	end

	always_comb begin
		vc = (v_q > MAW'(smax_q)) ? MAW'(smax_q) : v_q;
		vc = (vc < MAW'(smin_q)) ? MAW'(smin_q) : vc;
	end

	always_comb begin
		state_d = state_q;
		dreq.start = 1'b0;
		dreq.numer = NW'(acc_q) + NW'(prod_q);
		dreq.denom = srange;
		case (state_q)
			SC_IDLE: if (start) state_d = clamp_en ? SC_MUL_D : SC_MUL_V;
			SC_MUL_D: state_d = SC_LO_START;
			SC_LO_START: begin
				dreq.start = 1'b1;
				dreq.numer = NW'(smin_q) * NW'(200) + NW'(prod_q);
				dreq.denom = DW'(200);
				state_d = SC_LO_WAIT;
			end
			SC_LO_WAIT: if (drsp.done) state_d = SC_HI_START;
			SC_HI_START: begin
				dreq.start = 1'b1;
				dreq.numer = NW'(smax_q) * NW'(200) - NW'(prod_q);
				dreq.denom = DW'(200);
				state_d = SC_HI_WAIT;
			end
			SC_HI_WAIT: if (drsp.done) state_d = SC_CLAMP;
			SC_CLAMP: state_d = SC_MUL_V;
			SC_MUL_V: state_d = (srange == '0) ? SC_DONE : SC_MUL_M;
			SC_MUL_M: state_d = SC_DIV_START;
			SC_DIV_START: begin
				dreq.start = 1'b1;
				state_d = SC_DIV_WAIT;
			end
			SC_DIV_WAIT: if (drsp.done) state_d = SC_DONE;
			SC_DONE: state_d = SC_IDLE;
			default: state_d = SC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: if (start) begin
				smin_q <= DW'($signed(ranges[15:0]));
				smax_q <= DW'($signed(ranges[31:16]));
				dmin_q <= DW'($signed(ranges[47:32]));
				drange_q <= DW'($signed(ranges[63:48])) - DW'($signed(ranges[47:32]));
				v_q <= MAW'(value);
			end
			SC_MUL_D: prod_q <= product;
			SC_LO_WAIT: if (drsp.done) smin_q <= DW'(quot);
			SC_HI_WAIT: if (drsp.done) smax_q <= DW'(quot);
			SC_CLAMP: v_q <= vc;
			SC_MUL_V: begin
				prod_q <= product;
				res_q <= 32'(dmin_q);
			end
			SC_MUL_M: begin
				acc_q <= prod_q;
				prod_q <= product;
			end
			SC_DIV_WAIT: if (drsp.done) begin
				if (quot > NW'(32'sh7FFF_FFFF)) res_q <= 32'sh7FFF_FFFF;
				else if (quot < NW'(32'sh8000_0000)) res_q <= 32'sh8000_0000;
				else res_q <= 32'(quot);
			end
			default: ;
		endcase
	end

	assign done = state_q == SC_DONE;
	assign result = res_q;
endmodule

FILE: rtl/core/touch_event_slot_filter_scaler.sv
// Top level: multitouch event filter with slot tracking and axis rescale.
//
// Input events arrive on the s_ stream, one event per item; each gives one
// item on the m_ stream or none. The user writes configuration on cfg_we with
// cfg_index and cfg_data only while the block is idle; it is not enforced.
// Events that need no rescale (keys, sync, slot, tracking id, ABS_X/Y, and
// scaled axes of an idle slot) are decided in the cycle they are accepted
// and show on m_ the next cycle; one item per cycle while m_tready is high.
// Rescaled axes run through a sequencer that shares one multiplier and one
// serial divider. Without clamping there is one division; with clamping
// (scale percent 1 to 99) three divisions: the low bound, the high bound
// and the result. A zero source range skips the last division. s_tready
// is low meanwhile.
// A finished item waits in the output register while m_tready is low; a new
// item is taken as soon as that register is free or drains in the same edge.
// Reset (arst_n low) sets all slots idle, forgets the current slot and loads
// the register defaults.
`include "touch_event_slot_filter_scaler_defines.svh"
module touch_event_slot_filter_scaler #(
	parameter int NUM_SLOTS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [47:0] s_tdata, // event_type, event_code, event_value
	output logic m_tvalid,
	input logic m_tready,
	output logic [47:0] m_tdata, // out_type, out_code, out_value
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [63:0] cfg_data
);
	import tessf_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	logic [6:0] pct_q;
	logic [4:0] dcnt_q;
	logic [3:0] sslot_q;
	logic [3:0] amask_q;
	logic [63:0] rng_q [4];

	slot_state_t slot_q [NUM_SLOTS];
	slot_state_t slot_aged [NUM_SLOTS];
	logic [SW-1:0] cur_q, cur_e;
	logic oor_q, oor_e, known_q, active_q, aged_active;
	logic busy_q, m_tvalid_q;
	logic [14:0] pend_q;
	logic [47:0] m_tdata_q;

	logic [4:0] ev_type;
	logic [9:0] ev_code;
	logic signed [31:0] ev_value;
	logic acc, fwd, do_scale, idle, trk_ok, slot_ok;
	logic [1:0] axis;
	logic is_axis;
	logic sc_done;
	logic signed [31:0] sc_res;

	assign ev_type = s_tdata[4:0];
	assign ev_code = s_tdata[14:5];
	assign ev_value = s_tdata[46:15];
	assign s_tready = !busy_q && (!m_tvalid_q || m_tready);
	assign acc = s_tvalid && s_tready;

	always_comb begin
		cur_e = cur_q;
		oor_e = oor_q;
		if (!known_q) begin
			if (32'(sslot_q) < 32'(NUM_SLOTS)) begin
				cur_e = SW'(sslot_q);
				oor_e = 1'b0;
			end else begin
				oor_e = 1'b1;
			end
		end
	end

	assign idle = oor_e || slot_q[cur_e] == ST_IDLE;
	assign trk_ok = !oor_e && (7'(cur_e) < 7'(dcnt_q));
	assign slot_ok = !ev_value[31] && (32'(ev_value) < 32'(NUM_SLOTS));

	always_comb begin
		aged_active = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			case (slot_q[i])
				ST_BEGIN: slot_aged[i] = ST_UPDATE;
				ST_END: slot_aged[i] = ST_IDLE;
				default: slot_aged[i] = slot_q[i];
			endcase
			if (slot_aged[i] != ST_IDLE) aged_active = 1'b1;
		end
	end

	always_comb begin
		is_axis = 1'b1;
		axis = 2'd0;
		case (ev_code)
			ABS_MT_POS_X: axis = 2'd0;
			ABS_MT_POS_Y: axis = 2'd1;
			ABS_MT_PRESS: axis = 2'd2;
			ABS_PRESS: axis = 2'd3;
			default: is_axis = 1'b0;
		endcase
	end

	always_comb begin
		fwd = 1'b0;
		do_scale = 1'b0;
		case (ev_type)
			EV_SYN: fwd = 1'b1;
			EV_KEY: fwd = ev_code inside {KEY_TOUCH, KEY_FINGER, KEY_TAP2,
				KEY_TAP3, KEY_TAP4, KEY_TAP5};
			EV_ABS: begin
				if (ev_code == ABS_X || ev_code == ABS_Y) fwd = active_q;
				else if (ev_code == ABS_SLOT_SEL) fwd = 1'b1;
				else if (ev_code == ABS_TRACK_ID) fwd = trk_ok;
				else if (is_axis) begin
					if (idle) begin
						fwd = 1'b1;
					end else if (amask_q[axis]) begin
						do_scale = 1'b1;
					end
				end
			end
			default: fwd = 1'b0;
		endcase
	end

	tessf_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.start(acc && do_scale),
		.ranges(rng_q[axis]),
		.pct(pct_q),
		.value(ev_value),
		.done(sc_done),
		.result(sc_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_q <= 7'd100;
			dcnt_q <= 5'd16;
			sslot_q <= 4'd0;
			amask_q <= 4'hF;
			for (int i = 0; i < 4; i++) rng_q[i] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE_PERCENT: pct_q <= cfg_data[6:0];
				REG_DEST_SLOT_COUNT: dcnt_q <= cfg_data[4:0];
				REG_START_SLOT: sslot_q <= cfg_data[3:0];
				REG_DEST_AXIS_MASK: amask_q <= cfg_data[3:0];
				default: rng_q[cfg_index[1:0]] <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) slot_q[i] <= ST_IDLE;
			cur_q <= '0;
			oor_q <= 1'b0;
			known_q <= 1'b0;
			active_q <= 1'b0;
		end else if (acc) begin
			if (ev_type == EV_SYN) begin
				slot_q <= slot_aged;
				active_q <= aged_active;
			end else if (ev_type == EV_ABS) begin
				known_q <= 1'b1;
				cur_q <= cur_e;
				oor_q <= oor_e;
				if (ev_code == ABS_SLOT_SEL) begin
					if (slot_ok) begin
						cur_q <= SW'(ev_value);
						oor_q <= 1'b0;
					end else begin
						oor_q <= 1'b1;
					end
				end else if (ev_code == ABS_TRACK_ID && trk_ok) begin
					if (ev_value != -32'sd1) begin
						slot_q[cur_e] <= ST_BEGIN;
						active_q <= 1'b1;
					end else begin
						slot_q[cur_e] <= ST_END;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			if (acc && fwd) m_tvalid_q <= 1'b1;
			if (acc && do_scale) busy_q <= 1'b1;
			if (sc_done) begin
				busy_q <= 1'b0;
				m_tvalid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) pend_q <= s_tdata[14:0];
		if (acc && fwd) m_tdata_q <= {1'b0, s_tdata[46:0]};
		if (sc_done) m_tdata_q <= {1'b0, sc_res, pend_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	`TESSF_ASSERT(a_busy_blocks, busy_q |-> !s_tready, "input taken during rescale")
	`TESSF_ASSERT(a_done_busy, sc_done |-> busy_q, "rescale finished while not busy")
	`TESSF_NEVER(a_done_full, sc_done && m_tvalid_q && !$past(m_tready), "output overwritten")
	`TESSF_ASSERT(a_busy_hold, busy_q && !sc_done |=> busy_q, "busy dropped without result")
endmodule

FILE: tb/tb.sv
// Testbench for the touch event slot filter and scaler: directed and random events against a predictor.
`timescale 1ns / 1ps
module tb;
	import tessf_pkg::*;

	localparam int N_SLOTS = 16;
	localparam int LIMIT = 2000000;

	localparam logic [2:0] REG_MT_X = 3'd4;
	localparam logic [2:0] REG_MT_Y = 3'd5;
	localparam logic [2:0] REG_MT_PRESS = 3'd6;
	localparam logic [2:0] REG_PRESS = 3'd7;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [47:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [47:0] m_tdata;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	touch_event_slot_filter_scaler #(.NUM_SLOTS(N_SLOTS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// filter configuration copy
	logic [6:0] pct;
	logic [4:0] dest_slots;
	logic [3:0] first_slot;
	logic [3:0] axis_mask;
	logic [63:0] ranges [4];

	// slot tracking copy
	slot_state_t slots [N_SLOTS];
	logic [3:0] cur_slot;
	bit slot_bad;
	bit slot_seen;
	bit touching;

	logic [47:0] expected_events [$];
	int unsigned cycles;
	int mismatches;
	int n_sent;
	int n_checked;
	int n_scaled;
	bit rx_stall_on;
	bit rx_hold;
	bit rx_hold_req;
	bit tx_idle_on;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic longint f16(logic [63:0] p, int sh);
		return longint'($signed(p[sh +: 16]));
	endfunction

	function automatic longint scaled_value(logic [63:0] p, longint v);
		longint smin, smax, dmin, dmax, srange, drange, d, lo, hi, r;
		smin = f16(p, 0);
		smax = f16(p, 16);
		dmin = f16(p, 32);
		dmax = f16(p, 48);
		srange = smax - smin;
		drange = dmax - dmin;
		if (pct >= 1 && pct <= 99) begin
			d = 100 - longint'(pct);
			lo = (200 * smin + d * srange) / 200;
			hi = (200 * smax - d * srange) / 200;
			smin = lo;
			smax = hi;
			srange = smax - smin;
			if (v > smax) v = smax;
			if (v < smin) v = smin;
		end
		if (srange == 0) return dmin;
		r = ((v - smin) * drange + dmin * srange) / srange;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r;
	endfunction

	function automatic void pick_slot(longint s);
		if (s >= 0 && s < N_SLOTS) begin
			cur_slot = s[3:0];
			slot_bad = 0;
		end else begin
			slot_bad = 1;
		end
	endfunction

	function automatic void predict_event(logic [4:0] et, logic [9:0] ec, logic [31:0] ev);
		longint v, res;
		bit idle;
		int ax;
		v = longint'($signed(ev));
		res = v;
		ax = -1;
		if (et == EV_KEY) begin
			if (!(ec == KEY_TOUCH || ec == KEY_FINGER || ec == KEY_TAP2 ||
			      ec == KEY_TAP3 || ec == KEY_TAP4 || ec == KEY_TAP5))
				return;
		end else if (et == EV_SYN) begin
			touching = 0;
			for (int i = 0; i < N_SLOTS; i++) begin
				if (slots[i] == ST_BEGIN) slots[i] = ST_UPDATE;
				else if (slots[i] == ST_END) slots[i] = ST_IDLE;
				if (slots[i] != ST_IDLE) touching = 1;
			end
		end else if (et == EV_ABS) begin
			if (!slot_seen) begin
				slot_seen = 1;
				pick_slot(longint'(first_slot));
			end
			idle = slot_bad || slots[cur_slot] == ST_IDLE;
			case (ec)
				ABS_X, ABS_Y: if (!touching) return;
				ABS_MT_POS_X: ax = 0;
				ABS_MT_POS_Y: ax = 1;
				ABS_MT_PRESS: ax = 2;
				ABS_PRESS: ax = 3;
				ABS_SLOT_SEL: pick_slot(v);
				ABS_TRACK_ID: begin
					if (slot_bad || cur_slot >= dest_slots) return;
					if (v != -1) begin
						touching = 1;
						slots[cur_slot] = ST_BEGIN;
					end else begin
						slots[cur_slot] = ST_END;
					end
				end
				default: return;
			endcase
			if (ax >= 0 && !idle) begin
				if (!axis_mask[ax]) return;
				res = scaled_value(ranges[ax], v);
				n_scaled++;
			end
		end else begin
			return;
		end
		expected_events.push_back({1'b0, res[31:0], ec, et});
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SCALE_PERCENT: pct = val[6:0];
			REG_DEST_SLOT_COUNT: dest_slots = val[4:0];
			REG_START_SLOT: first_slot = val[3:0];
			REG_DEST_AXIS_MASK: axis_mask = val[3:0];
			default: ranges[idx - 4] = val;
		endcase
	endtask

	// sender idles in bursts when enabled; valid stays up between back-to-back items
	task automatic send_event(logic [4:0] et, logic [9:0] ec, logic [31:0] ev);
		int gap;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, ev, ec, et};
		predict_event(et, ec, ev);
		n_sent++;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_events.size() != 0) @(negedge clk);
		repeat (250) @(negedge clk);
	endtask

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				rx_hold = 1;
				m_tready <= 1'b0;
				repeat (400) @(negedge clk);
				rx_hold = 0;
				rx_hold_req = 0;
			end else if (rx_stall_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		logic [47:0] want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item %h", m_tdata);
				end else begin
					want = expected_events.pop_front();
					n_checked++;
					if (m_tdata[4:0] !== want[4:0] || m_tdata[14:5] !== want[14:5] ||
					    m_tdata[46:15] !== want[46:15] || m_tdata[47] !== 1'b0) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: type %0d/%0d code %0d/%0d value %0d/%0d",
								want[4:0], m_tdata[4:0], want[14:5], m_tdata[14:5],
								$signed(want[46:15]), $signed(m_tdata[46:15]));
					end
				end
			end
		end
	end

	function automatic logic [63:0] pack_ranges(int smin, int smax, int dmin, int dmax);
		return {dmax[15:0], dmin[15:0], smax[15:0], smin[15:0]};
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'h7FFFFFFF;
			2: return 32'h80000000;
			default: return $urandom_range(0, 70000) - 35000;
		endcase
	endfunction

	task automatic test_directed();
		send_event(EV_ABS, ABS_X, 32'd5);
		send_event(EV_ABS, ABS_MT_POS_X, 32'd100);
		send_event(EV_KEY, KEY_TOUCH, 32'd1);
		send_event(EV_KEY, KEY_FINGER, 32'd1);
		send_event(EV_KEY, KEY_TAP5, 32'd0);
		send_event(EV_KEY, KEY_TAP2, 32'd1);
		send_event(EV_KEY, KEY_TAP3, 32'd1);
		send_event(EV_KEY, KEY_TAP4, 32'd1);
		send_event(EV_KEY, 10'd1023, 32'd1);
		send_event(5'd31, 10'd0, 32'hFFFFFFFF);
		send_event(EV_ABS, ABS_SLOT_SEL, 32'd2);
		send_event(EV_ABS, ABS_TRACK_ID, 32'd7);
		send_event(EV_ABS, ABS_MT_POS_X, 32'h7FFFFFFF);
		send_event(EV_ABS, ABS_MT_POS_Y, 32'h80000000);
		send_event(EV_ABS, ABS_MT_PRESS, 32'd30);
		send_event(EV_ABS, ABS_PRESS, 32'd40);
		send_event(EV_SYN, 10'd0, 32'd0);
		send_event(EV_ABS, ABS_Y, 32'd9);
		send_event(EV_ABS, ABS_SLOT_SEL, 32'hFFFFFFFF);
		send_event(EV_ABS, ABS_MT_POS_X, 32'd50);
		send_event(EV_ABS, ABS_TRACK_ID, 32'd3);
		send_event(EV_ABS, ABS_SLOT_SEL, 32'd2);
		send_event(EV_ABS, ABS_TRACK_ID, 32'hFFFFFFFF);
		send_event(EV_ABS, 10'd999, 32'd1);
		send_event(EV_SYN, 10'd0, 32'd0);
		settle();
	endtask

	task automatic test_random(int count);
		int s;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 15))
				0: send_event(5'($urandom_range(0, 31)), 10'($urandom_range(0, 1023)),
					$urandom);
				1: send_event(EV_KEY, 10'($urandom_range(0, 3) == 0 ?
					$urandom_range(0, 1023) : KEY_TOUCH), $urandom_range(0, 1));
				2, 3: begin
					s = $urandom_range(0, 9) == 0 ? $urandom_range(16, 40) - 20 :
						$urandom_range(0, 15);
					send_event(EV_ABS, ABS_SLOT_SEL, s);
				end
				4: send_event(EV_ABS, ABS_TRACK_ID,
					$urandom_range(0, 2) == 0 ? 32'hFFFFFFFF : $urandom);
				5: send_event(EV_SYN, 10'($urandom_range(0, 3)), $urandom);
				6: send_event(EV_ABS, 10'($urandom_range(0, 1)), rand_value());
				7, 8, 9: send_event(EV_ABS, ABS_MT_POS_X, rand_value());
				10, 11: send_event(EV_ABS, ABS_MT_POS_Y, rand_value());
				12: send_event(EV_ABS, ABS_MT_PRESS, rand_value());
				13: send_event(EV_ABS, ABS_PRESS, rand_value());
				14: send_event(EV_ABS, 10'($urandom_range(0, 1023)), $urandom);
				default: begin
					send_event(EV_ABS, ABS_TRACK_ID, $urandom_range(0, 500));
					send_event(EV_ABS, ABS_MT_POS_X, rand_value());
					send_event(EV_ABS, ABS_MT_POS_Y, rand_value());
					send_event(EV_SYN, 10'd0, 32'd0);
				end
			endcase
		end
		settle();
	endtask

	task automatic random_config(logic [6:0] p, logic [4:0] dc, logic [3:0] ss, logic [3:0] am);
		write_reg(REG_SCALE_PERCENT, 64'(p));
		write_reg(REG_DEST_SLOT_COUNT, 64'(dc));
		write_reg(REG_START_SLOT, 64'(ss));
		write_reg(REG_DEST_AXIS_MASK, 64'(am));
		write_reg(REG_MT_X, {$urandom, $urandom});
		write_reg(REG_MT_Y, pack_ranges(-32768, 32767, 32767, -32768));
		write_reg(REG_MT_PRESS, pack_ranges(0, 255, 0, 1023));
		write_reg(REG_PRESS, $urandom_range(0, 1) ? 64'd0 : {$urandom, $urandom});
	endtask

	task automatic test_backpressure();
		rx_hold_req = 1;
		while (!rx_hold) @(negedge clk);
		for (int i = 0; i < 30; i++)
			send_event(EV_KEY, KEY_TOUCH, i);
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		n_sent = 0;
		n_checked = 0;
		n_scaled = 0;
		rx_stall_on = 1;
		rx_hold = 0;
		rx_hold_req = 0;
		tx_idle_on = 1;
		pct = 7'd100;
		dest_slots = 5'd16;
		first_slot = 4'd0;
		axis_mask = 4'hF;
		for (int i = 0; i < 4; i++) ranges[i] = '0;
		for (int i = 0; i < N_SLOTS; i++) slots[i] = ST_IDLE;
		cur_slot = '0;
		slot_bad = 0;
		slot_seen = 0;
		touching = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_reg(REG_MT_X, pack_ranges(0, 1000, 0, 4095));
		write_reg(REG_MT_Y, pack_ranges(-500, 500, 100, -100));
		write_reg(REG_MT_PRESS, pack_ranges(0, 255, 0, 255));
		write_reg(REG_PRESS, pack_ranges(7, 7, -5, 9));
		test_directed();
		test_backpressure();
		random_config(7'd1, 5'd1, 4'd15, 4'hF);
		test_random(350);
		random_config(7'd99, 5'd16, 4'd3, 4'h5);
		test_random(350);
		random_config(7'd0, 5'd8, 4'd0, 4'hA);
		test_random(350);
		random_config(7'd127, 5'd31, 4'd7, 4'h0);
		test_random(300);
		random_config(7'($urandom_range(1, 100)), 5'($urandom_range(1, 16)),
			4'($urandom_range(0, 15)), 4'hF);
		rx_stall_on = 0;
		tx_idle_on = 0;
		test_random(350);

		$display("sent %0d events, checked %0d output items, %0d rescaled",
			n_sent, n_checked, n_scaled);
		$display("covered keys, sync, slot and tracking changes, clamped and plain rescale");
		if (mismatches == 0 && expected_events.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d items missing", mismatches, expected_events.size());
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/tessf_pkg.sv
rtl/core/tessf_div.sv
rtl/core/tessf_scale.sv
rtl/core/touch_event_slot_filter_scaler.sv
tb/tb.sv
